// ===== design/assert_macros.svh =====
// Assertion helpers shared by the repair block.
// Needs nothing else; files that check their logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define WF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define WF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/wfir_pkg.sv =====
// Shared types and constants of the weak flux interval repair block.
// No dependencies; every module of the block imports it.
package wfir_pkg;

  localparam int unsigned CELL_W         = 16;
  localparam int unsigned CELL_RESET     = 2000;
  localparam int unsigned FLUX_W         = 32;
  localparam int unsigned CNT_W          = 32;
  localparam int unsigned TDATA_IN_W     = 32;
  localparam int unsigned TDATA_OUT_W    = 72;
  localparam int unsigned CLS_N          = 12;

  // Bounds on 5*t in units of T: weak-free bands are [8,12] [13,17] [18,22],
  // normal bands are [9,11] [14,16] [19,21].
  localparam int unsigned CLS_MULT [CLS_N] = '{8, 9, 11, 12, 13, 14, 16, 17, 18, 19, 21, 22};

  typedef enum logic [1:0] {
    CLS_NORMAL = 2'd0,
    CLS_MAYBE  = 2'd1,
    CLS_WEAK   = 2'd2
  } wclass_e;

  typedef struct packed {
    logic    last;
    wclass_e cls;
  } look_meta_t;

  typedef struct packed {
    logic shift;
    logic load;
  } look_ctrl_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } hist_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic drain;
  } win_stat_t;

  typedef struct packed {
    logic [FLUX_W-1:0] flux;
    wclass_e           cls;
    logic              corrected;
    logic [CNT_W-1:0]  total;
    logic              last;
  } rslt_t;

endpackage

// ===== design/wfir_look_cell.sv =====
// One slot of the lookahead window: holds an original interval and its tags.
// Depends on wfir_pkg; shifts toward the head or loads the incoming request.
module wfir_look_cell #(
  parameter int unsigned INTERVAL_WIDTH = 32
) (
  input  logic                       clk_i,
  input  wfir_pkg::look_ctrl_t       ctrl_i,
  input  logic [INTERVAL_WIDTH-1:0]  new_val_i,
  input  wfir_pkg::look_meta_t       new_meta_i,
  input  logic [INTERVAL_WIDTH-1:0]  up_val_i,
  input  wfir_pkg::look_meta_t       up_meta_i,
  output logic [INTERVAL_WIDTH-1:0]  val_o,
  output wfir_pkg::look_meta_t       meta_o
);
  import wfir_pkg::*;

  logic [INTERVAL_WIDTH-1:0] val_q;
  look_meta_t                meta_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      val_q  <= new_val_i;
      meta_q <= new_meta_i;
    end else if (ctrl_i.shift) begin
      val_q  <= up_val_i;
      meta_q <= up_meta_i;
    end
  end

  assign val_o  = val_q;
  assign meta_o = meta_q;

endmodule

// ===== design/wfir_hist_cell.sv =====
// One slot of the history row: a repaired interval, newest at slot zero.
// Depends on wfir_pkg; empty slots read as zero so the running sum stays exact.
module wfir_hist_cell #(
  parameter int unsigned INTERVAL_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wfir_pkg::hist_ctrl_t       ctrl_i,
  input  logic [INTERVAL_WIDTH-1:0]  up_val_i,
  output logic [INTERVAL_WIDTH-1:0]  val_o
);
  import wfir_pkg::*;

  logic [INTERVAL_WIDTH-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (ctrl_i.clear) begin
      val_q <= '0;
    end else if (ctrl_i.shift) begin
      val_q <= up_val_i;
    end
  end

  assign val_o = val_q;

endmodule

// ===== design/wfir_repair.sv =====
// Window control and head decision: counts, running sums, nearest multiple.
// Depends on wfir_pkg; drives the lookahead and history cell rows.
module wfir_repair #(
  parameter int unsigned NEIGHBOR_SPAN  = 4,
  parameter int unsigned INTERVAL_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wfir_pkg::CELL_W-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_last_i,
  input  logic [INTERVAL_WIDTH-1:0]         in_val_i,
  input  logic                              out_free_i,
  input  logic [INTERVAL_WIDTH-1:0]         head_val_i,
  input  wfir_pkg::look_meta_t              head_meta_i,
  input  logic [INTERVAL_WIDTH-1:0]         hist_tail_i,
  output logic                              push_o,
  output logic                              emit_o,
  output wfir_pkg::look_ctrl_t              look_ctrl_o [NEIGHBOR_SPAN+1],
  output wfir_pkg::hist_ctrl_t              hist_ctrl_o,
  output wfir_pkg::win_stat_t               stat_o,
  output wfir_pkg::rslt_t                   rslt_o
);
  import wfir_pkg::*;

  localparam int unsigned N      = NEIGHBOR_SPAN;
  localparam int unsigned IW     = INTERVAL_WIDTH;
  localparam int unsigned WD     = N + 1;
  localparam int unsigned NMAX   = 2 * N;
  localparam int unsigned CW     = $clog2(N + 2);
  localparam int unsigned HCW    = $clog2(N + 1);
  localparam int unsigned NW     = $clog2(NMAX + 1);
  localparam int unsigned SUM_W  = IW + $clog2(NMAX + 1);
  localparam int unsigned HS_W   = IW + $clog2(N + 1);
  localparam int unsigned PS_W   = IW + $clog2(N + 2);
  localparam int unsigned TW     = CELL_W + $clog2(7 * NMAX + 1);
  localparam int unsigned CMP_W  = (SUM_W + 1 > TW) ? SUM_W + 1 : TW;
  localparam int unsigned KT_W   = CELL_W + 3;

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             drain_q, drain_d;
  logic [HCW-1:0]   hcnt_q, hcnt_d;
  logic [HS_W-1:0]  hist_sum_q, hist_sum_d;
  logic [PS_W-1:0]  pend_sum_q, pend_sum_d;
  logic [CNT_W-1:0] corr_q, corr_d;

  logic [TW-1:0]    thr5_q [NMAX+1];
  logic [TW-1:0]    thr7_q [NMAX+1];
  logic [IW-1:0]    cand_q [3];
  logic [IW-1:0]    cand_d [3];
  logic [KT_W-1:0]  kt     [3];

  logic             full, empty, want, emit, push, last_item;
  logic [SUM_W-1:0] neigh_sum;
  logic [NW-1:0]    nbr;
  logic [CMP_W-1:0] twice;
  logic [1:0]       pick;
  logic [IW-1:0]    res;
  logic             changed;
  logic [CNT_W-1:0] total;

  // Replacement candidates k*T, clipped to the interval width.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      kt[k] = KT_W'(cfg_wdata_i) * KT_W'(k + 2);
      if ((kt[k] >> IW) != '0) begin
        cand_d[k] = '1;
      end else begin
        cand_d[k] = IW'(kt[k]);
      end
    end
  end

  // Decision thresholds 5*T*n and 7*T*n for every neighbor count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n <= NMAX; n++) begin
        thr5_q[n] <= TW'(5 * n * CELL_RESET);
        thr7_q[n] <= TW'(7 * n * CELL_RESET);
      end
      for (int k = 0; k < 3; k++) begin
        cand_q[k] <= IW'((k + 2) * CELL_RESET);
      end
    end else if (cfg_we_i) begin
      for (int n = 0; n <= NMAX; n++) begin
        thr5_q[n] <= TW'(cfg_wdata_i) * TW'(5 * n);
        thr7_q[n] <= TW'(cfg_wdata_i) * TW'(7 * n);
      end
      for (int k = 0; k < 3; k++) begin
        cand_q[k] <= cand_d[k];
      end
    end
  end

  assign full      = (cnt_q == CW'(WD));
  assign empty     = (cnt_q == '0);
  assign want      = full || (drain_q && !empty);
  assign emit      = want && out_free_i;
  assign push      = in_valid_i && !drain_q && (!full || emit);
  assign last_item = drain_q && (cnt_q == CW'(1));

  // Head decision: neighbors are the history row plus the window behind the head.
  always_comb begin
    neigh_sum = SUM_W'(hist_sum_q) + SUM_W'(pend_sum_q) - SUM_W'(head_val_i);
    nbr       = NW'(hcnt_q) + NW'(cnt_q) - NW'(1);
    twice     = CMP_W'(neigh_sum) << 1;
    if (twice <= CMP_W'(thr5_q[nbr])) begin
      pick = 2'd0;
    end else if (twice <= CMP_W'(thr7_q[nbr])) begin
      pick = 2'd1;
    end else begin
      pick = 2'd2;
    end
    if (head_meta_i.cls == CLS_WEAK && nbr != '0) begin
      res = cand_q[pick];
    end else begin
      res = head_val_i;
    end
    changed = (res != head_val_i);
    if (changed && corr_q != '1) begin
      total = corr_q + CNT_W'(1);
    end else begin
      total = corr_q;
    end
  end

  always_comb begin
    cnt_d      = cnt_q + CW'(push) - CW'(emit);
    pend_sum_d = pend_sum_q + (push ? PS_W'(in_val_i) : '0) - (emit ? PS_W'(head_val_i) : '0);
    drain_d    = drain_q;
    hcnt_d     = hcnt_q;
    hist_sum_d = hist_sum_q;
    corr_d     = corr_q;
    if (emit && last_item) begin
      // end of stream: start the next one fresh
      drain_d    = 1'b0;
      hcnt_d     = '0;
      hist_sum_d = '0;
      corr_d     = '0;
    end else begin
      if (push && in_last_i) begin
        drain_d = 1'b1;
      end
      if (emit) begin
        hcnt_d     = (hcnt_q == HCW'(N)) ? hcnt_q : hcnt_q + HCW'(1);
        hist_sum_d = hist_sum_q + HS_W'(res) - HS_W'(hist_tail_i);
        corr_d     = total;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      drain_q    <= 1'b0;
      hcnt_q     <= '0;
      hist_sum_q <= '0;
      pend_sum_q <= '0;
      corr_q     <= '0;
    end else begin
      cnt_q      <= cnt_d;
      drain_q    <= drain_d;
      hcnt_q     <= hcnt_d;
      hist_sum_q <= hist_sum_d;
      pend_sum_q <= pend_sum_d;
      corr_q     <= corr_d;
    end
  end

  // New request lands in the first free slot after this cycle's shift.
  always_comb begin
    for (int i = 0; i < WD; i++) begin
      look_ctrl_o[i].shift = emit;
      look_ctrl_o[i].load  = push && (emit ? (cnt_q == CW'(i + 1)) : (cnt_q == CW'(i)));
    end
  end

  assign hist_ctrl_o.shift = emit && !last_item;
  assign hist_ctrl_o.clear = emit && last_item;

  assign stat_o.full  = full;
  assign stat_o.empty = empty;
  assign stat_o.drain = drain_q;

  assign rslt_o.flux      = FLUX_W'(res);
  assign rslt_o.cls       = head_meta_i.cls;
  assign rslt_o.corrected = changed;
  assign rslt_o.total     = total;
  assign rslt_o.last      = last_item;

  assign push_o = push;
  assign emit_o = emit;

endmodule

// ===== design/weak_flux_interval_repair.sv =====
// Top level of the weak flux interval repair block: input stage, classifier,
// cell rows, output register. Depends on wfir_pkg, assert_macros.svh, the cells and wfir_repair.
//
// Usage:
//   s_axis carries flux intervals in ns (tdata) with tlast on the final one.
//   m_axis returns one result per interval, in order; tlast marks the final
//   result of a stream. cfg_we_i/cfg_wdata_i set the bit cell time T while idle.
//   Each interval is classed against 2T, 3T, 4T; a definitely weak one is
//   replaced by the multiple nearest the mean of up to NEIGHBOR_SPAN repaired
//   earlier intervals and NEIGHBOR_SPAN original later ones.
// Latency and throughput:
//   One interval per cycle, a rate set by the head decision loop, while the
//   receiver is ready. A result leaves NEIGHBOR_SPAN intervals after its own,
//   once the request completing its window has gone from the input register
//   into the window. tlast flushes up to NEIGHBOR_SPAN+1 results, one per cycle
//   while ready; the input takes one more request, then waits for the flush.
// Reset: window and history empty, counters zero, T = 2000 ns.
// Stall: while m_axis_tready is low the result is held; input keeps filling
//   the window and stops once the window and input register are full.
`include "assert_macros.svh"

module weak_flux_interval_repair #(
  parameter int unsigned NEIGHBOR_SPAN  = 4,
  parameter int unsigned INTERVAL_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wfir_pkg::CELL_W-1:0]        cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] flux_interval
  input  logic [wfir_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] flux_out, [33:32] weak_class, [34] corrected,
  // [66:35] corrections_total, [71:67] zero
  output logic [wfir_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);
  import wfir_pkg::*;

  localparam int unsigned N     = NEIGHBOR_SPAN;
  localparam int unsigned IW    = INTERVAL_WIDTH;
  localparam int unsigned WD    = N + 1;
  localparam int unsigned CLS_W = (IW + 3 > CELL_W + 5) ? IW + 3 : CELL_W + 5;

  logic [CLS_W-1:0] cls_thr_q [CLS_N];

  logic             s0_valid_q, s0_valid_d;
  logic [IW-1:0]    s0_val_q;
  logic             s0_last_q;
  logic             accept;

  logic [CLS_W-1:0] five_t;
  logic             in_band, in_norm;
  look_meta_t       new_meta;

  logic             push, emit, out_free;
  look_ctrl_t       look_ctrl [WD];
  hist_ctrl_t       hist_ctrl;
  win_stat_t        stat;
  rslt_t            rslt;

  logic [IW-1:0]    win_val  [WD];
  look_meta_t       win_meta [WD];
  logic [IW-1:0]    hist_val [N];

  logic             out_valid_q, out_valid_d;
  rslt_t            out_q;

  // Class bounds m*T, reloaded whenever T is written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < CLS_N; m++) begin
        cls_thr_q[m] <= CLS_W'(CLS_MULT[m] * CELL_RESET);
      end
    end else if (cfg_we_i) begin
      for (int m = 0; m < CLS_N; m++) begin
        cls_thr_q[m] <= CLS_W'(cfg_wdata_i) * CLS_W'(CLS_MULT[m]);
      end
    end
  end

  // Input register.
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !s0_valid_q || push;

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (accept) begin
      s0_valid_d = 1'b1;
    end else if (push) begin
      s0_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= s0_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_val_q  <= s_axis_tdata[IW-1:0];
      s0_last_q <= s_axis_tlast;
    end
  end

  // Classify on the original value: compare 5t against the band edges.
  always_comb begin
    five_t  = (CLS_W'(s0_val_q) << 2) + CLS_W'(s0_val_q);
    in_band = 1'b0;
    in_norm = 1'b0;
    for (int b = 0; b < 3; b++) begin
      if (five_t >= cls_thr_q[4 * b] && five_t <= cls_thr_q[4 * b + 3]) begin
        in_band = 1'b1;
      end
      if (five_t >= cls_thr_q[4 * b + 1] && five_t <= cls_thr_q[4 * b + 2]) begin
        in_norm = 1'b1;
      end
    end
    new_meta.last = s0_last_q;
    if (in_norm) begin
      new_meta.cls = CLS_NORMAL;
    end else if (in_band) begin
      new_meta.cls = CLS_MAYBE;
    end else begin
      new_meta.cls = CLS_WEAK;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  wfir_repair #(
    .NEIGHBOR_SPAN  (N),
    .INTERVAL_WIDTH (IW)
  ) u_repair (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s0_valid_q),
    .in_last_i   (s0_last_q),
    .in_val_i    (s0_val_q),
    .out_free_i  (out_free),
    .head_val_i  (win_val[0]),
    .head_meta_i (win_meta[0]),
    .hist_tail_i (hist_val[N-1]),
    .push_o      (push),
    .emit_o      (emit),
    .look_ctrl_o (look_ctrl),
    .hist_ctrl_o (hist_ctrl),
    .stat_o      (stat),
    .rslt_o      (rslt)
  );

  // Lookahead row, head at slot zero.
  for (genvar i = 0; i < WD; i++) begin : g_look
    logic [IW-1:0] up_val;
    look_meta_t    up_meta;
    if (i == WD - 1) begin : g_end
      assign up_val  = '0;
      assign up_meta = '0;
    end else begin : g_mid
      assign up_val  = win_val[i+1];
      assign up_meta = win_meta[i+1];
    end
    wfir_look_cell #(
      .INTERVAL_WIDTH (IW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (look_ctrl[i]),
      .new_val_i  (s0_val_q),
      .new_meta_i (new_meta),
      .up_val_i   (up_val),
      .up_meta_i  (up_meta),
      .val_o      (win_val[i]),
      .meta_o     (win_meta[i])
    );
  end

  // History row, newest repaired value at slot zero.
  for (genvar i = 0; i < N; i++) begin : g_hist
    logic [IW-1:0] up_val;
    if (i == 0) begin : g_first
      assign up_val = rslt.flux[IW-1:0];
    end else begin : g_next
      assign up_val = hist_val[i-1];
    end
    wfir_hist_cell #(
      .INTERVAL_WIDTH (IW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (hist_ctrl),
      .up_val_i (up_val),
      .val_o    (hist_val[i])
    );
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= rslt;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {5'b0, out_q.total, out_q.corrected, out_q.cls, out_q.flux};

  `WF_ASSERT(a_no_overrun, clk_i, rst_ni, !(push && stat.full && !emit), "window overrun")
  `WF_ASSERT_NEXT(a_flush_done, clk_i, rst_ni, emit && rslt.last, stat.empty && !stat.drain, "flush incomplete")
  `WF_ASSERT_IMPL(a_repair_weak_only, clk_i, rst_ni, emit && rslt.cls != CLS_WEAK, !rslt.corrected, "non-weak interval changed")
  `WF_ASSERT(a_total_counts, clk_i, rst_ni, !(emit && rslt.corrected && rslt.total == '0), "correction count lost")

endmodule

// ===== tb/sv/weak_flux_interval_repair_test.sv =====
// Self-checking testbench for weak_flux_interval_repair: directed interval
// streams, then random streams under several cell times, against a predictor.
// Depends on wfir_pkg and the weak_flux_interval_repair RTL.
module weak_flux_interval_repair_test;
  import wfir_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 40;
  localparam int SPAN           = 4;
  localparam int N_ROWS         = 26;

  typedef enum logic [1:0] {
    ROW_CELL,
    ROW_INTERVAL,
    ROW_KNOWN
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [31:0] val;
    logic        lst;
    rslt_t       res;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CELL_W-1:0]      cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  // Predictor state: cell time, repaired history (newest first), pending window
  logic [15:0] cell_ns;
  logic [31:0] prev_out [SPAN];
  logic [31:0] window [SPAN+1];
  int          hist_n;
  int          pend_n;
  logic [31:0] fix_total;

  rslt_t    exp_q [$];
  dir_row_t dir_rows [N_ROWS];
  bit       burst_req;
  int       errs;
  int       n_items;
  int       n_streams;
  int       n_cells;
  int       n_results;
  int       n_fixed;
  int       idle_cycles;

  weak_flux_interval_repair dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] absdiff(logic [63:0] a, logic [63:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic wclass_e class_of(logic [63:0] t, logic [63:0] c);
    logic [63:0] best;
    logic [63:0] d;
    best = absdiff(t, 2 * c);
    for (int k = 3; k <= 4; k++) begin
      d = absdiff(t, 64'(k) * c);
      if (d < best) best = d;
    end
    if (5 * best > 2 * c) return CLS_WEAK;
    if (5 * best > c) return CLS_MAYBE;
    return CLS_NORMAL;
  endfunction

  function automatic void restart_stream();
    foreach (prev_out[i]) prev_out[i] = '0;
    foreach (window[i]) window[i] = '0;
    hist_n    = 0;
    pend_n    = 0;
    fix_total = '0;
  endfunction

  // Retire the oldest pending interval, repairing it if definitely weak.
  function automatic rslt_t repair_head(logic fin);
    logic [63:0] c;
    logic [63:0] orig;
    logic [63:0] res;
    logic [63:0] sum;
    logic [63:0] n;
    logic [63:0] bestd;
    logic [63:0] d;
    int          bestk;
    wclass_e     cls;
    logic        chg;
    rslt_t       r;
    c    = 64'(cell_ns);
    orig = 64'(window[0]);
    res  = orig;
    cls  = class_of(orig, c);
    if (cls == CLS_WEAK) begin
      sum = '0;
      n   = '0;
      for (int i = 0; i < hist_n && i < SPAN; i++) begin
        sum += 64'(prev_out[i]);
        n++;
      end
      for (int i = 1; i < pend_n && i <= SPAN; i++) begin
        sum += 64'(window[i]);
        n++;
      end
      if (n > 0) begin
        bestk = 2;
        bestd = absdiff(sum, 2 * c * n);
        for (int k = 3; k <= 4; k++) begin
          d = absdiff(sum, 64'(k) * c * n);
          if (d < bestd) begin
            bestd = d;
            bestk = k;
          end
        end
        res = 64'(bestk) * c;
        if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
      end
    end
    chg = (res != orig);
    if (chg && fix_total != 32'hFFFF_FFFF) fix_total++;
    for (int i = 0; i + 1 < pend_n && i < SPAN; i++) window[i] = window[i+1];
    if (pend_n > 0) pend_n--;
    for (int i = SPAN - 1; i > 0; i--) prev_out[i] = prev_out[i-1];
    prev_out[0] = res[31:0];
    if (hist_n < SPAN) hist_n++;
    r.flux      = res[31:0];
    r.cls       = cls;
    r.corrected = chg;
    r.total     = fix_total;
    r.last      = fin;
    return r;
  endfunction

  function automatic void absorb_interval(logic [31:0] v, logic l);
    int n;
    n = 0;
    if (pend_n > SPAN) pend_n = SPAN;
    window[pend_n] = v;
    pend_n++;
    if (l) begin
      while (pend_n > 0 && n < SPAN + 1) begin
        exp_q.push_back(repair_head(pend_n == 1));
        n++;
      end
      restart_stream();
    end else if (pend_n > SPAN) begin
      exp_q.push_back(repair_head(1'b0));
    end
  endfunction

  function automatic dir_row_t row_cell(logic [15:0] c);
    dir_row_t r;
    r      = '{kind: ROW_CELL, val: '0, lst: 1'b0, res: '0};
    r.val  = 32'(c);
    return r;
  endfunction

  function automatic dir_row_t row_interval(logic [31:0] v, logic l);
    return '{kind: ROW_INTERVAL, val: v, lst: l, res: '0};
  endfunction

  // One-interval stream: no neighbours, so the value passes through unchanged.
  function automatic dir_row_t row_known(logic [31:0] v, wclass_e cls);
    dir_row_t r;
    r             = '{kind: ROW_KNOWN, val: v, lst: 1'b1, res: '0};
    r.res.flux      = v;
    r.res.cls       = cls;
    r.res.corrected = 1'b0;
    r.res.total     = '0;
    r.res.last      = 1'b1;
    return r;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mostly near 2T/3T/4T with jitter up to half a cell, some full-range noise.
  function automatic logic [31:0] draw_interval(logic [15:0] c);
    logic [63:0] v;
    int          k;
    if ($urandom_range(0, 99) < 12) return $urandom;
    k = $urandom_range(2, 4);
    v = 64'(k) * 64'(c) + 64'($urandom_range(0, c)) - 64'(c / 2);
    return v[31:0];
  endfunction

  task automatic send_item(input logic [31:0] v, input logic l, input bit known,
                           input rslt_t want);
    int base;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    base = exp_q.size();
    absorb_interval(v, l);
    if (known) begin
      while (exp_q.size() > base) void'(exp_q.pop_back());
      exp_q.push_back(want);
    end
    n_items++;
    if (l) n_streams++;
  endtask

  task automatic pause_sender(input int g);
    if (g > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  // Drain every pending result, let the pipeline settle, then load T.
  task automatic write_cell(input logic [15:0] c);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cell_ns = c;
    n_cells++;
  endtask

  // Result side: random stalls, calm stretches, and one long hold-off on request.
  initial begin
    int  hold;
    bit  calm_rx;
    hold          = 0;
    calm_rx       = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) < 2) calm_rx = ~calm_rx;
      if (burst_req) begin
        hold      = 150;
        burst_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (calm_rx || $urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end
    end
  end

  always @(posedge clk_i) begin
    rslt_t       want;
    logic [31:0] got_flux;
    logic [1:0]  got_cls;
    logic        got_corr;
    logic [31:0] got_total;
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else if (m_axis_tvalid && m_axis_tready) begin
        got_flux  = m_axis_tdata[31:0];
        got_cls   = m_axis_tdata[33:32];
        got_corr  = m_axis_tdata[34];
        got_total = m_axis_tdata[66:35];
        n_results++;
        if (got_corr) n_fixed++;
        if (exp_q.size() == 0) begin
          $error("unexpected result: flux_out %0d with nothing pending", got_flux);
          errs++;
        end else begin
          want = exp_q.pop_front();
          if (got_flux !== want.flux) begin
            $error("flux_out: expected %0d, got %0d", want.flux, got_flux);
            errs++;
          end
          if (got_cls !== want.cls) begin
            $error("weak_class: expected %0d, got %0d", want.cls, got_cls);
            errs++;
          end
          if (got_corr !== want.corrected) begin
            $error("corrected: expected %0d, got %0d", want.corrected, got_corr);
            errs++;
          end
          if (got_total !== want.total) begin
            $error("corrections_total: expected %0d, got %0d", want.total, got_total);
            errs++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_out: expected %0d, got %0d", want.last, m_axis_tlast);
            errs++;
          end
        end
      end
    end
  end

  initial begin
    logic [15:0] cells [6];
    int          sent;
    int          len;
    bit          calm;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    burst_req     = 1'b0;
    errs          = 0;
    n_items       = 0;
    n_streams     = 0;
    n_cells       = 0;
    n_results     = 0;
    n_fixed       = 0;
    idle_cycles   = 0;
    cell_ns       = 16'(CELL_RESET);
    restart_stream();

    dir_rows = '{
      row_known(32'd4000, CLS_NORMAL),
      row_known(32'd0, CLS_WEAK),
      row_known(32'hFFFF_FFFF, CLS_WEAK),
      row_known(32'd4500, CLS_MAYBE),
      row_known(32'd4800, CLS_MAYBE),   // 5*d equals 2T: still only possibly weak
      row_known(32'd4801, CLS_WEAK),
      row_interval(32'd4000, 1'b0),
      row_interval(32'd6000, 1'b0),
      row_interval(32'd8000, 1'b0),
      row_interval(32'd3000, 1'b0),
      row_interval(32'd4000, 1'b0),
      row_interval(32'd6000, 1'b0),
      row_interval(32'd8000, 1'b0),
      row_interval(32'd4000, 1'b1),
      // neighbour mean sits exactly between 2T and 3T: lower multiple wins
      row_interval(32'd4000, 1'b0),
      row_interval(32'd0, 1'b0),
      row_interval(32'd6000, 1'b1),
      row_cell(16'hFFFF),
      row_known(32'd131070, CLS_NORMAL),
      row_interval(32'd131070, 1'b0),
      row_interval(32'd50000, 1'b0),
      row_interval(32'd262140, 1'b1),
      // zero cell time: any nonzero interval is weak and repairs to zero
      row_cell(16'd0),
      row_interval(32'd0, 1'b0),
      row_interval(32'd7, 1'b0),
      row_interval(32'd0, 1'b1)
    };

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CELL) begin
        write_cell(dir_rows[i].val[15:0]);
      end else begin
        send_item(dir_rows[i].val, dir_rows[i].lst, dir_rows[i].kind == ROW_KNOWN,
                  dir_rows[i].res);
        pause_sender(pick_gap(1'b0));
      end
    end

    cells = '{16'd2000, 16'd1, 16'hFFFF, 16'($urandom_range(2, 65534)), 16'd0,
              16'($urandom_range(100, 5000))};
    foreach (cells[p]) begin
      write_cell(cells[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1:    len = $urandom_range(1, 4);
          2:       len = $urandom_range(21, 40);
          default: len = $urandom_range(5, 20);
        endcase
        calm = ($urandom_range(0, 3) == 0);
        // Long stream against a held-off receiver: window fills, input stalls.
        if (p == 0 && sent == 0) begin
          burst_req = 1'b1;
          len       = 30;
          calm      = 1'b1;
        end
        for (int j = 0; j < len; j++) begin
          send_item(draw_interval(cells[p]), j == len - 1, 1'b0, '0);
          pause_sender(pick_gap(calm));
        end
        pause_sender(pick_gap(1'b0));
        sent += len;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Sent %0d intervals in %0d streams under %0d cell times, zero and full scale included.",
             n_items, n_streams, n_cells);
    $display("Compared %0d results, %0d of them repaired.", n_results, n_fixed);
    if (errs == 0 && exp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
